[rtl/core/dfpb_pkg.sv]
// Shared codes, control word type and microprogram of the page buffer controller.
`default_nettype none

package dfpb_pkg;

	localparam int MAX_REQUEST_DEF   = 2048;
	localparam int MAX_PAGES_DEF     = 8192;
	localparam int MAX_PAGE_SIZE_DEF = 1056;

	localparam int STEP_W = 5;

	// Request types.
	localparam logic [1:0] REQ_READ   = 2'd0;
	localparam logic [1:0] REQ_WRITE  = 2'd1;
	localparam logic [1:0] REQ_FLUSH  = 2'd2;
	localparam logic [1:0] REQ_REOPEN = 2'd3;

	// Command kinds on the result channel.
	localparam logic [2:0] K_TO_PAGE = 3'd0;
	localparam logic [2:0] K_TO_BUF  = 3'd1;
	localparam logic [2:0] K_WRBUF   = 3'd2;
	localparam logic [2:0] K_READ    = 3'd3;
	localparam logic [2:0] K_DONE    = 3'd4;

	// Register indexes of the configuration port.
	localparam logic [1:0] R_PAGE_SIZE    = 2'd0;
	localparam logic [1:0] R_PAGE_BITS    = 2'd1;
	localparam logic [1:0] R_PAGE_COUNT   = 2'd2;
	localparam logic [1:0] R_READ_VARIANT = 2'd3;

	// Datapath operations.
	localparam logic [3:0] OP_NONE    = 4'd0;
	localparam logic [3:0] OP_LOAD    = 4'd1;
	localparam logic [3:0] OP_FSIZE   = 4'd2;
	localparam logic [3:0] OP_LEN     = 4'd3;
	localparam logic [3:0] OP_PLACE   = 4'd4;
	localparam logic [3:0] OP_CHUNK   = 4'd5;
	localparam logic [3:0] OP_WB      = 4'd6;
	localparam logic [3:0] OP_LOADBUF = 4'd7;
	localparam logic [3:0] OP_REOPEN  = 4'd8;
	localparam logic [3:0] OP_WRITE   = 4'd9;
	localparam logic [3:0] OP_READ    = 4'd10;

	// Jump conditions.
	localparam logic [3:0] C_NEVER   = 4'd0;
	localparam logic [3:0] C_ALWAYS  = 4'd1;
	localparam logic [3:0] C_NOIN    = 4'd2;
	localparam logic [3:0] C_DIVBUSY = 4'd3;
	localparam logic [3:0] C_WR      = 4'd4;
	localparam logic [3:0] C_FL      = 4'd5;
	localparam logic [3:0] C_RO      = 4'd6;
	localparam logic [3:0] C_CLEAN   = 4'd7;
	localparam logic [3:0] C_OUTSIDE = 4'd8;
	localparam logic [3:0] C_LENZERO = 4'd9;
	localparam logic [3:0] C_SAME    = 4'd10;

	// Page sources for emitted commands.
	localparam logic [1:0] PG_ZERO = 2'd0;
	localparam logic [1:0] PG_BUF  = 2'd1;
	localparam logic [1:0] PG_WORK = 2'd2;

	typedef struct packed {
		logic [3:0]        op;
		logic              emit;
		logic [2:0]        kind;
		logic [1:0]        psrc;
		logic [3:0]        cond;
		logic [STEP_W-1:0] target;
	} ucode_t;

	function automatic ucode_t mk(input logic [3:0] op, input logic emit,
			input logic [2:0] kind, input logic [1:0] psrc, input logic [3:0] cond,
			input int target);
		ucode_t w;
		w.op     = op;
		w.emit   = emit;
		w.kind   = kind;
		w.psrc   = psrc;
		w.cond   = cond;
		w.target = STEP_W'(target);
		return w;
	endfunction

	// The microprogram. Step 0 waits for a request; step 18 sends the done word.
	function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
		ucode_t w;
		case (step)
			5'd0:    w = mk(OP_LOAD,    1'b0, K_DONE,    PG_ZERO, C_NOIN,    0);
			5'd1:    w = mk(OP_FSIZE,   1'b0, K_DONE,    PG_ZERO, C_NEVER,   0);
			5'd2:    w = mk(OP_LEN,     1'b0, K_DONE,    PG_ZERO, C_NEVER,   0);
			5'd3:    w = mk(OP_NONE,    1'b0, K_DONE,    PG_ZERO, C_DIVBUSY, 3);
			5'd4:    w = mk(OP_PLACE,   1'b0, K_DONE,    PG_ZERO, C_WR,      12);
			5'd5:    w = mk(OP_NONE,    1'b0, K_DONE,    PG_ZERO, C_CLEAN,   7);
			5'd6:    w = mk(OP_WB,      1'b1, K_TO_PAGE, PG_BUF,  C_NEVER,   0);
			5'd7:    w = mk(OP_NONE,    1'b0, K_DONE,    PG_ZERO, C_FL,      18);
			5'd8:    w = mk(OP_NONE,    1'b0, K_DONE,    PG_ZERO, C_RO,      11);
			5'd9:    w = mk(OP_NONE,    1'b0, K_DONE,    PG_ZERO, C_OUTSIDE, 18);
			5'd10:   w = mk(OP_READ,    1'b1, K_READ,    PG_WORK, C_ALWAYS,  18);
			5'd11:   w = mk(OP_REOPEN,  1'b1, K_TO_BUF,  PG_ZERO, C_ALWAYS,  18);
			5'd12:   w = mk(OP_CHUNK,   1'b0, K_DONE,    PG_ZERO, C_LENZERO, 18);
			5'd13:   w = mk(OP_NONE,    1'b0, K_DONE,    PG_ZERO, C_SAME,    17);
			5'd14:   w = mk(OP_NONE,    1'b0, K_DONE,    PG_ZERO, C_CLEAN,   16);
			5'd15:   w = mk(OP_WB,      1'b1, K_TO_PAGE, PG_BUF,  C_NEVER,   0);
			5'd16:   w = mk(OP_LOADBUF, 1'b1, K_TO_BUF,  PG_WORK, C_NEVER,   0);
			5'd17:   w = mk(OP_WRITE,   1'b1, K_WRBUF,   PG_ZERO, C_ALWAYS,  12);
			5'd18:   w = mk(OP_NONE,    1'b1, K_DONE,    PG_ZERO, C_ALWAYS,  0);
			default: w = mk(OP_NONE,    1'b0, K_DONE,    PG_ZERO, C_ALWAYS,  0);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[rtl/core/dfpb_in_if.sv]
// Request channel: valid/ready handshake carrying one file request.
`default_nettype none

interface dfpb_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [23:0] position;
	logic [11:0] request_length;

	modport source (output valid, req_type, position, request_length, input ready);
	modport sink (input valid, req_type, position, request_length, output ready);
endinterface

`default_nettype wire

[rtl/core/dfpb_out_if.sv]
// Command channel: valid/ready handshake carrying one flash command word.
`default_nettype none

interface dfpb_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd_kind;
	logic [7:0]  addr_byte_high;
	logic [7:0]  addr_byte_mid;
	logic [7:0]  addr_byte_low;
	logic [12:0] page_index;
	logic [10:0] byte_offset;
	logic [11:0] transfer_length;
	logic [2:0]  dummy_bytes;
	logic        last;

	modport source (output valid, cmd_kind, addr_byte_high, addr_byte_mid, addr_byte_low,
		page_index, byte_offset, transfer_length, dummy_bytes, last, input ready);
	modport sink (input valid, cmd_kind, addr_byte_high, addr_byte_mid, addr_byte_low,
		page_index, byte_offset, transfer_length, dummy_bytes, last, output ready);
endinterface

`default_nettype wire

[rtl/core/dfpb_div.sv]
// Restoring divider, one quotient bit per cycle, splitting a position into page and offset.
`default_nettype none

module dfpb_div import dfpb_pkg::*; #(
	parameter int QW = 13
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [23:0]   dividend,
	input  wire logic [10:0]   divisor,
	output logic               busy,
	output logic [QW-1:0]      quot,
	output logic [10:0]        rem
);

	localparam int CW = $clog2(QW + 1);

	logic [CW-1:0] cnt_q;
	logic [QW-1:0] quot_q;
	logic [10:0]   rem_q;
	logic [10:0]   divisor_q;
	logic [11:0]   trial;
	logic          ge;
	logic [23:0]   high_part;

	assign high_part = dividend >> QW;
	assign trial     = {rem_q, quot_q[QW-1]};
	assign ge        = trial >= {1'b0, divisor_q};
	assign busy      = cnt_q != '0;
	assign quot      = quot_q;
	assign rem       = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(QW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= high_part[10:0];
			quot_q    <= dividend[QW-1:0];
			divisor_q <= divisor;
		end else if (busy) begin
			rem_q  <= ge ? 11'(trial - {1'b0, divisor_q}) : trial[10:0];
			quot_q <= QW'({quot_q, ge});
		end
	end

endmodule

`default_nettype wire

[rtl/core/dataflash_page_buffer_controller_top.sv]
// Top level of the page buffer controller: configuration, sequencer and datapath.
// Usage
// The block turns byte-file requests on the request channel (read, write, flush, reopen
// at page zero, with a byte position and a length) into flash commands on the command
// channel. Each command word carries its kind, the three packed address bytes, page,
// offset, data length and dummy byte count; every request ends with a done word whose
// last flag is set and whose length is the number of bytes transferred.
// Configuration (page size, page address bits, page count, read variant) is written
// through the APB port at byte addresses 0, 4, 8 and 12; the user must write it only
// while the block is idle, as the block itself does not enforce this. A request is
// accepted only while the sequencer sits at its wait step, so the block works on one
// request at a time. Its first command word waits on the bit-serial divider that splits
// the position into page and offset (QW quotient bits, 13 at the default page limit);
// each further page that a write crosses costs a write-back, a page load and a buffer
// write at one word per step. The next request can be taken in the cycle after the done
// word has been loaded into the output register.
// Commands wait in a single output register; while the receiver stalls, the sequencer
// holds at its emitting step and resumes as soon as the word is taken.
// Reset clears the configuration to its defaults, marks page zero as held in the buffer
// and the buffer as clean; no clearing pass is needed.
`default_nettype none

module dataflash_page_buffer_controller_top import dfpb_pkg::*; #(
	parameter int MAX_REQUEST   = MAX_REQUEST_DEF,
	parameter int MAX_PAGES     = MAX_PAGES_DEF,
	parameter int MAX_PAGE_SIZE = MAX_PAGE_SIZE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	dfpb_in_if.sink          request,
	dfpb_out_if.source       command,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// Quotient width of the position split: enough bits for the largest page index.
	localparam int QW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

	// Configuration registers.
	logic [10:0] page_size_q;
	logic [3:0]  page_bits_q;
	logic [13:0] page_count_q;
	logic        read_variant_q;

	// Sequencer and persistent state.
	logic [STEP_W-1:0] step_q;
	logic              dirty_q;
	logic [12:0]       buf_page_q;

	// Working registers of the current request.
	logic [1:0]  type_q;
	logic [23:0] pos_q;
	logic [11:0] req_q;
	logic [24:0] fsize_q;
	logic        inside_q;
	logic [11:0] len_q;
	logic [11:0] total_q;
	logic [12:0] pg_q;
	logic [10:0] off_q;
	logic [11:0] chunk_q;

	// Output register.
	logic        out_valid_q;
	logic [2:0]  out_kind_q;
	logic [7:0]  out_high_q;
	logic [7:0]  out_mid_q;
	logic [7:0]  out_low_q;
	logic [12:0] out_page_q;
	logic [10:0] out_off_q;
	logic [11:0] out_len_q;
	logic [2:0]  out_dummy_q;
	logic        out_last_q;

	ucode_t      ctrl;
	logic        adv;
	logic        take;
	logic        cond_true;
	logic        cfg_wr;

	logic [10:0] ps_eff;
	logic [3:0]  pb_eff;
	logic [13:0] pc_eff;
	logic [24:0] room_file;
	logic [11:0] room_page;

	logic          div_busy;
	logic [QW-1:0] div_quot;
	logic [10:0]   div_rem;

	logic [12:0] e_page;
	logic [10:0] e_off;
	logic [11:0] e_len;
	logic [2:0]  e_dummy;
	logic [7:0]  e_high;
	logic [7:0]  e_mid;
	logic [7:0]  e_low;

	// ---------------------------------------------------------------- configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q    <= 11'd264;
			page_bits_q    <= 4'd9;
			page_count_q   <= 14'd2048;
			read_variant_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				R_PAGE_SIZE:    page_size_q    <= pwdata[10:0];
				R_PAGE_BITS:    page_bits_q    <= pwdata[3:0];
				R_PAGE_COUNT:   page_count_q   <= pwdata[13:0];
				R_READ_VARIANT: read_variant_q <= pwdata[0];
				default:        read_variant_q <= read_variant_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			R_PAGE_SIZE:    prdata = {21'd0, page_size_q};
			R_PAGE_BITS:    prdata = {28'd0, page_bits_q};
			R_PAGE_COUNT:   prdata = {18'd0, page_count_q};
			R_READ_VARIANT: prdata = {31'd0, read_variant_q};
			default:        prdata = '0;
		endcase
	end

	// Registers outside their legal range saturate into it.
	always_comb begin
		ps_eff = page_size_q;
		if (page_size_q < 11'd256) begin
			ps_eff = 11'd256;
		end else if ({21'd0, page_size_q} > 32'(MAX_PAGE_SIZE)) begin
			ps_eff = 11'(MAX_PAGE_SIZE);
		end
		pb_eff = page_bits_q;
		if (page_bits_q < 4'd9) begin
			pb_eff = 4'd9;
		end else if (page_bits_q > 4'd11) begin
			pb_eff = 4'd11;
		end
		pc_eff = page_count_q;
		if (page_count_q == '0) begin
			pc_eff = 14'd1;
		end else if ({18'd0, page_count_q} > 32'(MAX_PAGES)) begin
			pc_eff = 14'(MAX_PAGES);
		end
	end

	// ---------------------------------------------------------------- sequencer
	assign ctrl          = ucode(step_q);
	assign request.ready = ctrl.op == OP_LOAD;
	assign take          = request.valid && request.ready;

	// An emitting step waits while the output register is full and not being taken.
	assign adv = !(ctrl.emit && out_valid_q && !command.ready);

	always_comb begin
		case (ctrl.cond)
			C_NEVER:   cond_true = 1'b0;
			C_ALWAYS:  cond_true = 1'b1;
			C_NOIN:    cond_true = !request.valid;
			C_DIVBUSY: cond_true = div_busy;
			C_WR:      cond_true = type_q == REQ_WRITE;
			C_FL:      cond_true = type_q == REQ_FLUSH;
			C_RO:      cond_true = type_q == REQ_REOPEN;
			C_CLEAN:   cond_true = !dirty_q;
			C_OUTSIDE: cond_true = !inside_q;
			C_LENZERO: cond_true = len_q == '0;
			C_SAME:    cond_true = pg_q == buf_page_q;
			default:   cond_true = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (adv) begin
			step_q <= cond_true ? ctrl.target : step_q + 1'b1;
		end
	end

	// ---------------------------------------------------------------- datapath
	dfpb_div #(
		.QW(QW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.op == OP_FSIZE),
		.dividend (pos_q),
		.divisor  (ps_eff),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign room_file = fsize_q - {1'b0, pos_q};
	assign room_page = 12'(ps_eff) - 12'(off_q);

	// Buffered page and dirty mark survive between requests.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q    <= 1'b0;
			buf_page_q <= '0;
		end else if (adv) begin
			case (ctrl.op)
				OP_WB:      dirty_q    <= 1'b0;
				OP_LOADBUF: buf_page_q <= pg_q;
				OP_REOPEN:  buf_page_q <= '0;
				OP_WRITE:   dirty_q    <= 1'b1;
				default:    dirty_q    <= dirty_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (ctrl.op)
				OP_LOAD: begin
					if (take) begin
						type_q  <= request.req_type;
						pos_q   <= request.position;
						total_q <= '0;
						if ({2'b0, request.request_length} > 14'(MAX_REQUEST)) begin
							req_q <= 12'(MAX_REQUEST);
						end else begin
							req_q <= request.request_length;
						end
					end
				end
				OP_FSIZE: fsize_q <= 25'({14'd0, ps_eff} * {11'd0, pc_eff});
				OP_LEN: begin
					inside_q <= {1'b0, pos_q} < fsize_q;
					if ({1'b0, pos_q} >= fsize_q) begin
						len_q <= '0;
					end else if ({13'd0, req_q} < room_file) begin
						len_q <= req_q;
					end else begin
						len_q <= room_file[11:0];
					end
				end
				OP_PLACE: begin
					pg_q  <= 13'(div_quot);
					off_q <= div_rem;
				end
				OP_CHUNK: chunk_q <= (len_q < room_page) ? len_q : room_page;
				OP_READ:  total_q <= len_q;
				OP_WRITE: begin
					// The next chunk starts at the head of the following page.
					len_q   <= len_q - chunk_q;
					total_q <= total_q + chunk_q;
					pg_q    <= pg_q + 1'b1;
					off_q   <= '0;
				end
				default: total_q <= total_q;
			endcase
		end
	end

	// ---------------------------------------------------------------- command word
	always_comb begin
		case (ctrl.psrc)
			PG_BUF:  e_page = buf_page_q;
			PG_WORK: e_page = pg_q;
			default: e_page = '0;
		endcase
		e_off = (ctrl.kind == K_WRBUF || ctrl.kind == K_READ) ? off_q : '0;
		case (ctrl.kind)
			K_WRBUF: e_len = chunk_q;
			K_READ:  e_len = len_q;
			K_DONE:  e_len = total_q;
			default: e_len = '0;
		endcase
		if (ctrl.kind == K_READ) begin
			e_dummy = read_variant_q ? 3'd1 : 3'd4;
		end else begin
			e_dummy = '0;
		end
		// Page bits above the in-page offset field go to the high byte, the rest
		// share the middle byte with the top of the offset.
		case (pb_eff)
			4'd10: begin
				e_high = 8'(e_page >> 6);
				e_mid  = 8'({e_page, 2'b0} + {12'd0, e_off[10:8]});
			end
			4'd11: begin
				e_high = 8'(e_page >> 5);
				e_mid  = 8'({e_page, 3'b0} + {13'd0, e_off[10:8]});
			end
			default: begin
				e_high = 8'(e_page >> 7);
				e_mid  = 8'({e_page, 1'b0} + {11'd0, e_off[10:8]});
			end
		endcase
		e_low = e_off[7:0];
		if (ctrl.kind == K_DONE) begin
			e_high = '0;
			e_mid  = '0;
			e_low  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit && adv) begin
			out_valid_q <= 1'b1;
		end else if (command.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit && adv) begin
			out_kind_q  <= ctrl.kind;
			out_high_q  <= e_high;
			out_mid_q   <= e_mid;
			out_low_q   <= e_low;
			out_page_q  <= e_page;
			out_off_q   <= e_off;
			out_len_q   <= e_len;
			out_dummy_q <= e_dummy;
			out_last_q  <= ctrl.kind == K_DONE;
		end
	end

	assign command.valid           = out_valid_q;
	assign command.cmd_kind        = out_kind_q;
	assign command.addr_byte_high  = out_high_q;
	assign command.addr_byte_mid   = out_mid_q;
	assign command.addr_byte_low   = out_low_q;
	assign command.page_index      = out_page_q;
	assign command.byte_offset     = out_off_q;
	assign command.transfer_length = out_len_q;
	assign command.dummy_bytes     = out_dummy_q;
	assign command.last            = out_last_q;

	// ---------------------------------------------------------------- assertions
	// A chunk is only ever written into the page that the buffer holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.emit && adv && ctrl.kind == K_WRBUF) |-> (pg_q == buf_page_q))
		else $error("buffer write issued for a page that is not loaded");

	// The position split must be complete before page and offset are taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_PLACE) |-> !div_busy)
		else $error("page and offset taken from an unfinished division");

	// Every buffer write moves at least one byte, or the write loop would not end.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.emit && adv && ctrl.kind == K_WRBUF) |-> (chunk_q != '0))
		else $error("empty buffer write chunk");

	// After a buffer write the buffer is marked dirty.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.emit && adv && ctrl.kind == K_WRBUF) |=> dirty_q)
		else $error("buffer not marked dirty after a write");

endmodule

`default_nettype wire
